[hw/rtl/turtle_pose_engine_defines.svh]
// Assertion macros used by the turtle pose engine top level
`ifndef TURTLE_POSE_ENGINE_DEFINES_SVH
`define TURTLE_POSE_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tpe_pkg.sv]
// Types, constants and tables of the turtle pose engine
`timescale 1ns / 1ps
package tpe_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 20;
	localparam int COLOUR_COUNT = 16;
	localparam int ANG_FRAC     = 24;
	localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
	localparam int MUL_SH       = 30 - FRAC_BITS;

	localparam int XW = 45;
	localparam int ZW = 36;
	localparam int HW = 25;
	localparam int MW = 51;

	localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);
	localparam logic [4:0] MOD_TOP   = 5'd9;

	localparam logic [HW-1:0] HEADING_MOD = HW'(360) << FRAC_BITS;
	localparam logic [HW-1:0] HD_90       = HW'(90) << FRAC_BITS;
	localparam logic [HW-1:0] HD_180      = HW'(180) << FRAC_BITS;
	localparam logic [HW-1:0] HD_270      = HW'(270) << FRAC_BITS;

	localparam logic signed [ZW-1:0] DEG90_Q24  = ZW'(90) << ANG_FRAC;
	localparam logic signed [ZW-1:0] DEG180_Q24 = ZW'(180) << ANG_FRAC;
	localparam logic signed [ZW-1:0] DEG360_Q24 = ZW'(360) << ANG_FRAC;
	localparam logic signed [ZW-1:0] MOD_OFF    = ZW'(HEADING_MOD) << MOD_TOP;

	localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
	localparam logic signed [XW-1:0] NORM_LIM = XW'(1) << 40;

	localparam logic [12:0] WIN_W_RST = 13'd640;
	localparam logic [12:0] WIN_H_RST = 13'd480;

	localparam logic [1:0] EDGE_FREE  = 2'd0;
	localparam logic [1:0] EDGE_FENCE = 2'd1;
	localparam logic [1:0] EDGE_WRAP  = 2'd2;

	localparam logic [2:0] CFG_WIN_W  = 3'd0;
	localparam logic [2:0] CFG_WIN_H  = 3'd1;
	localparam logic [2:0] CFG_EDGE   = 3'd2;
	localparam logic [2:0] CFG_PEN    = 3'd3;
	localparam logic [2:0] CFG_COLOUR = 3'd4;
	localparam logic [2:0] CFG_STROKE = 3'd5;
	localparam logic [2:0] CFG_STYLE  = 3'd6;

	typedef enum logic [2:0] {
		OP_MOVE    = 3'd0,
		OP_ROTATE  = 3'd1,
		OP_SETANG  = 3'd2,
		OP_SETXY   = 3'd3,
		OP_SETX    = 3'd4,
		OP_SETY    = 3'd5,
		OP_TOWARDS = 3'd6,
		OP_HOME    = 3'd7
	} op_t;

	typedef struct packed {
		logic [12:0] win_w;
		logic [12:0] win_h;
		logic [1:0]  edge_mode;
		logic        pen_on;
		logic [3:0]  colour;
		logic [7:0]  stroke_w;
		logic [1:0]  style;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       vprep;
		logic       mod_step;
		logic       norm_step;
		logic       cord_step;
		logic       mul;
		logic       fin;
		logic       out_load;
		logic [4:0] idx;
	} ctl_t;

	typedef struct packed {
		op_t  op;
		logic spec;
		logic norm_done;
	} sts_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [HW-1:0]      heading;
		logic               segment_valid;
		logic signed [31:0] seg_from_x;
		logic signed [31:0] seg_from_y;
		logic signed [31:0] seg_to_x;
		logic signed [31:0] seg_to_y;
		logic [3:0]         seg_colour;
		logic [7:0]         seg_width;
		logic [1:0]         seg_style;
		logic               error_code;
	} res_t;

	// atan(2^-k) in degrees, Q24
	function automatic logic [29:0] atan_q24(input logic [4:0] k);
		logic [29:0] a;
		case (k)
			5'd0:  a = 30'd754974720;
			5'd1:  a = 30'd445687602;
			5'd2:  a = 30'd235489088;
			5'd3:  a = 30'd119537938;
			5'd4:  a = 30'd60000934;
			5'd5:  a = 30'd30029717;
			5'd6:  a = 30'd15018523;
			5'd7:  a = 30'd7509720;
			5'd8:  a = 30'd3754917;
			5'd9:  a = 30'd1877466;
			5'd10: a = 30'd938734;
			5'd11: a = 30'd469367;
			5'd12: a = 30'd234684;
			5'd13: a = 30'd117342;
			5'd14: a = 30'd58671;
			5'd15: a = 30'd29335;
			5'd16: a = 30'd14668;
			5'd17: a = 30'd7334;
			5'd18: a = 30'd3667;
			5'd19: a = 30'd1833;
			5'd20: a = 30'd917;
			5'd21: a = 30'd458;
			5'd22: a = 30'd229;
			5'd23: a = 30'd115;
			5'd24: a = 30'd57;
			5'd25: a = 30'd29;
			5'd26: a = 30'd14;
			5'd27: a = 30'd7;
			5'd28: a = 30'd4;
			5'd29: a = 30'd2;
			5'd30: a = 30'd1;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

[hw/rtl/tpe_cmd_if.sv]
// Command channel: operation and operands
`timescale 1ns / 1ps
interface tpe_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [15:0] distance;
	logic signed [31:0] angle_value;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;

	modport source (output valid, operation, distance, angle_value, target_x, target_y,
		input ready);
	modport sink (input valid, operation, distance, angle_value, target_x, target_y,
		output ready);
endinterface

[hw/rtl/tpe_res_if.sv]
// Result channel: pose, segment and error code
`timescale 1ns / 1ps
interface tpe_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [24:0]        heading;
	logic               segment_valid;
	logic signed [31:0] seg_from_x;
	logic signed [31:0] seg_from_y;
	logic signed [31:0] seg_to_x;
	logic signed [31:0] seg_to_y;
	logic [3:0]         seg_colour;
	logic [7:0]         seg_width;
	logic [1:0]         seg_style;
	logic               error_code;

	modport source (output valid, pos_x, pos_y, heading, segment_valid, seg_from_x,
		seg_from_y, seg_to_x, seg_to_y, seg_colour, seg_width, seg_style, error_code,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, segment_valid, seg_from_x,
		seg_from_y, seg_to_x, seg_to_y, seg_colour, seg_width, seg_style, error_code,
		output ready);
endinterface

[hw/rtl/tpe_cfg.sv]
// Configuration registers with range checks on write
`timescale 1ns / 1ps
module tpe_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [12:0]   cfg_wdata,
	output tpe_pkg::cfg_t cfg
);
	import tpe_pkg::*;

	cfg_t cfg_q;

	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_w     <= WIN_W_RST;
			cfg_q.win_h     <= WIN_H_RST;
			cfg_q.edge_mode <= EDGE_FREE;
			cfg_q.pen_on    <= 1'b1;
			cfg_q.colour    <= 4'd1;
			cfg_q.stroke_w  <= 8'd1;
			cfg_q.style     <= 2'd0;
		end else if (cfg_we) begin
			// drop out-of-range values, keep the old setting
			case (cfg_index)
				CFG_WIN_W: begin
					if (cfg_wdata >= 13'd1 && cfg_wdata <= 13'd4096) cfg_q.win_w <= cfg_wdata;
				end
				CFG_WIN_H: begin
					if (cfg_wdata >= 13'd1 && cfg_wdata <= 13'd4096) cfg_q.win_h <= cfg_wdata;
				end
				CFG_EDGE: begin
					if (cfg_wdata[1:0] != 2'd3) cfg_q.edge_mode <= cfg_wdata[1:0];
				end
				CFG_PEN: cfg_q.pen_on <= cfg_wdata[0];
				CFG_COLOUR: begin
					if (int'(cfg_wdata[3:0]) < COLOUR_COUNT) cfg_q.colour <= cfg_wdata[3:0];
				end
				CFG_STROKE: begin
					if (cfg_wdata[7:0] != 8'd0) cfg_q.stroke_w <= cfg_wdata[7:0];
				end
				CFG_STYLE: begin
					if (cfg_wdata[1:0] != 2'd3) cfg_q.style <= cfg_wdata[1:0];
				end
				default: ;
			endcase
		end
	end
endmodule

[hw/rtl/tpe_ctrl.sv]
// Command sequencer of the turtle pose engine
`timescale 1ns / 1ps
module tpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  tpe_pkg::sts_t sts,
	output tpe_pkg::ctl_t ctl
);
	import tpe_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PREP  = 9'b000000010,
		S_VPREP = 9'b000000100,
		S_MOD   = 9'b000001000,
		S_NORM  = 9'b000010000,
		S_CORD  = 9'b000100000,
		S_MUL   = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       res_valid_q;

	assign res_valid = res_valid_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd_ready = 1'b0;
		ctl       = '0;
		ctl.idx   = cnt_q;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				ctl.prep = 1'b1;
				case (sts.op)
					OP_MOVE: begin
						cnt_d   = 5'd0;
						state_d = S_CORD;
					end
					OP_ROTATE, OP_SETANG: begin
						cnt_d   = MOD_TOP;
						state_d = S_MOD;
					end
					OP_TOWARDS: state_d = S_VPREP;
					default: state_d = S_FIN;
				endcase
			end
			S_VPREP: begin
				ctl.vprep = 1'b1;
				cnt_d     = 5'd0;
				state_d   = S_NORM;
			end
			S_NORM: begin
				if (sts.spec) state_d = S_FIN;
				else if (sts.norm_done) state_d = S_CORD;
				else ctl.norm_step = 1'b1;
			end
			S_CORD: begin
				ctl.cord_step = 1'b1;
				cnt_d         = cnt_q + 5'd1;
				if (cnt_q == CORD_LAST) state_d = (sts.op == OP_MOVE) ? S_MUL : S_FIN;
			end
			S_MOD: begin
				ctl.mod_step = 1'b1;
				cnt_d        = cnt_q - 5'd1;
				if (cnt_q == 5'd0) state_d = S_FIN;
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				ctl.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the result register is free
				if (!res_valid_q || res_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 5'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ctl.out_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end
endmodule

[hw/rtl/tpe_dp.sv]
// Pose registers, shared CORDIC, heading reduction and result register
`timescale 1ns / 1ps
module tpe_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tpe_pkg::ctl_t      ctl,
	input  tpe_pkg::cfg_t      cfg,
	input  logic [2:0]         operation,
	input  logic signed [15:0] distance,
	input  logic signed [31:0] angle_value,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	output tpe_pkg::sts_t      sts,
	output tpe_pkg::res_t      res
);
	import tpe_pkg::*;

	op_t                op_q;
	logic signed [15:0] dist_q;
	logic signed [31:0] ang_q, tx_q, ty_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [HW-1:0]      hd_q, hd_new_q;
	logic signed [XW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic               neg_q, spec_q, place_q;
	logic signed [MW-1:0] mul_s_q, mul_c_q;
	logic signed [31:0] nxt_x_q, nxt_y_q;
	res_t               res_q;

	// rotation range reduction
	logic signed [ZW-1:0] z0, z1, z2;
	logic                 zneg;
	// heading sums offset by a multiple of 360 degrees to stay positive
	logic signed [ZW-1:0] rot_v, set_v;
	logic [ZW-1:0]        mod_sub;
	logic signed [32:0]   xd, yd;
	// cordic step
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	logic                 sub_dir;
	logic signed [16:0]   dist_e;
	// finish
	logic signed [MW-1:0] dx, dy;
	logic signed [51:0]   sum_x, sum_y;
	logic signed [ZW-1:0] zr, zw;
	// output
	logic signed [31:0] w_fx, h_fx, home_x, home_y;
	logic               changed, fence_bad, draw;
	logic signed [31:0] wx, wy, px_n, py_n;
	logic [HW-1:0]      hd_n;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd2147483647) r = 32'sh7fffffff;
		else if (v < -52'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	assign sts.op        = op_q;
	assign sts.spec      = spec_q;
	assign sts.norm_done = (cx_q >= NORM_LIM) || (cy_q >= NORM_LIM) || (cy_q <= -NORM_LIM);
	assign res           = res_q;

	always_comb begin
		z0 = ZW'(hd_q) << ANG_SH;
		z1 = (z0 > DEG180_Q24) ? z0 - DEG360_Q24 : z0;
		z2 = z1;
		zneg = 1'b0;
		if (z1 > DEG90_Q24) begin
			z2   = z1 - DEG180_Q24;
			zneg = 1'b1;
		end else if (z1 < -DEG90_Q24) begin
			z2   = z1 + DEG180_Q24;
			zneg = 1'b1;
		end
		rot_v = $signed({11'd0, hd_q}) + {{4{ang_q[31]}}, ang_q} + MOD_OFF;
		set_v = {{4{ang_q[31]}}, ang_q} + MOD_OFF;
		mod_sub = ZW'(HEADING_MOD) << ctl.idx;
		xd = {tx_q[31], tx_q} - {pos_x_q[31], pos_x_q};
		yd = {pos_y_q[31], pos_y_q} - {ty_q[31], ty_q};
	end

	always_comb begin
		xs = cx_q >>> ctl.idx;
		ys = cy_q >>> ctl.idx;
		at = ZW'(atan_q24(ctl.idx));
		// drive z to zero on a move, y to zero on a bearing
		sub_dir = (op_q == OP_MOVE) ? (cz_q >= 0) : (cy_q < 0);
		dist_e = neg_q ? -{dist_q[15], dist_q} : {dist_q[15], dist_q};
	end

	always_comb begin
		dx = (mul_s_q + (MW'(1) <<< (MUL_SH - 1))) >>> MUL_SH;
		dy = (mul_c_q + (MW'(1) <<< (MUL_SH - 1))) >>> MUL_SH;
		sum_x = 52'(pos_x_q) + 52'(dx);
		sum_y = 52'(pos_y_q) - 52'(dy);
		zr = (cz_q + (ZW'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
		zw = (zr < 0) ? zr + ZW'(HEADING_MOD) : zr;
	end

	always_comb begin
		w_fx   = signed'(32'(cfg.win_w) << FRAC_BITS);
		h_fx   = signed'(32'(cfg.win_h) << FRAC_BITS);
		home_x = signed'(32'(cfg.win_w) << (FRAC_BITS - 1));
		home_y = signed'(32'(cfg.win_h) << (FRAC_BITS - 1));
		changed = place_q && (nxt_x_q != pos_x_q || nxt_y_q != pos_y_q);
		fence_bad = (cfg.edge_mode == EDGE_FENCE) && (nxt_x_q < 0 || nxt_y_q < 0 ||
			nxt_x_q >= w_fx || nxt_y_q >= h_fx);
		draw = changed && !fence_bad && cfg.pen_on;
		wx = nxt_x_q;
		wy = nxt_y_q;
		if (cfg.edge_mode == EDGE_WRAP) begin
			if (nxt_x_q < 0) wx = nxt_x_q + w_fx;
			else if (nxt_x_q >= w_fx) wx = nxt_x_q - w_fx;
			if (nxt_y_q < 0) wy = nxt_y_q + h_fx;
			else if (nxt_y_q >= h_fx) wy = nxt_y_q - h_fx;
		end
		px_n = pos_x_q;
		py_n = pos_y_q;
		hd_n = hd_q;
		case (op_q)
			OP_HOME: begin
				px_n = home_x;
				py_n = home_y;
				hd_n = '0;
			end
			OP_ROTATE, OP_SETANG, OP_TOWARDS: hd_n = hd_new_q;
			default: begin
				if (changed && !fence_bad) begin
					px_n = wx;
					py_n = wy;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= signed'(32'(WIN_W_RST) << (FRAC_BITS - 1));
			pos_y_q <= signed'(32'(WIN_H_RST) << (FRAC_BITS - 1));
			hd_q    <= '0;
		end else if (ctl.out_load) begin
			pos_x_q <= px_n;
			pos_y_q <= py_n;
			hd_q    <= hd_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q   <= op_t'(operation);
			dist_q <= distance;
			ang_q  <= angle_value;
			tx_q   <= target_x;
			ty_q   <= target_y;
		end

		if (ctl.prep) begin
			case (op_q)
				OP_MOVE: begin
					cx_q  <= GAIN_Q30;
					cy_q  <= '0;
					cz_q  <= z2;
					neg_q <= zneg;
				end
				OP_ROTATE: cz_q <= rot_v;
				OP_SETANG: cz_q <= set_v;
				OP_TOWARDS: begin
					cy_q <= XW'(xd);
					cx_q <= XW'(yd);
				end
				default: ;
			endcase
		end

		if (ctl.vprep) begin
			// straight-axis bearings skip the iterations
			spec_q <= (cy_q == 0) || (cx_q == 0);
			if (cy_q == 0) hd_new_q <= (cx_q > 0) ? '0 : HD_180;
			else if (cx_q == 0) hd_new_q <= (cy_q > 0) ? HD_90 : HD_270;
			if (cx_q < 0) begin
				cx_q <= -cx_q;
				cy_q <= -cy_q;
				cz_q <= DEG180_Q24;
			end else begin
				cz_q <= '0;
			end
		end

		if (ctl.mod_step) begin
			if ($unsigned(cz_q) >= mod_sub) cz_q <= cz_q - signed'(mod_sub);
		end

		if (ctl.norm_step) begin
			cx_q <= cx_q <<< 1;
			cy_q <= cy_q <<< 1;
		end

		if (ctl.cord_step) begin
			if (sub_dir) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end

		if (ctl.mul) begin
			mul_s_q <= $signed(cy_q[33:0]) * dist_e;
			mul_c_q <= $signed(cx_q[33:0]) * dist_e;
		end

		if (ctl.fin) begin
			place_q <= (op_q == OP_MOVE) || (op_q == OP_SETXY) || (op_q == OP_SETX) ||
				(op_q == OP_SETY);
			case (op_q)
				OP_MOVE: begin
					nxt_x_q <= sat32(sum_x);
					nxt_y_q <= sat32(sum_y);
				end
				OP_ROTATE, OP_SETANG: begin
					nxt_x_q  <= pos_x_q;
					nxt_y_q  <= pos_y_q;
					hd_new_q <= cz_q[HW-1:0];
				end
				OP_SETXY: begin
					nxt_x_q <= tx_q;
					nxt_y_q <= ty_q;
				end
				OP_SETX: begin
					nxt_x_q <= tx_q;
					nxt_y_q <= pos_y_q;
				end
				OP_SETY: begin
					nxt_x_q <= pos_x_q;
					nxt_y_q <= ty_q;
				end
				OP_TOWARDS: begin
					nxt_x_q <= pos_x_q;
					nxt_y_q <= pos_y_q;
					if (!spec_q) hd_new_q <= zw[HW-1:0];
				end
				default: begin
					nxt_x_q <= pos_x_q;
					nxt_y_q <= pos_y_q;
				end
			endcase
		end

		if (ctl.out_load) begin
			res_q.pos_x         <= px_n;
			res_q.pos_y         <= py_n;
			res_q.heading       <= hd_n;
			res_q.segment_valid <= draw;
			res_q.seg_from_x    <= draw ? pos_x_q : '0;
			res_q.seg_from_y    <= draw ? pos_y_q : '0;
			res_q.seg_to_x      <= draw ? nxt_x_q : '0;
			res_q.seg_to_y      <= draw ? nxt_y_q : '0;
			res_q.seg_colour    <= draw ? cfg.colour : '0;
			res_q.seg_width     <= draw ? cfg.stroke_w : '0;
			res_q.seg_style     <= draw ? cfg.style : '0;
			res_q.error_code    <= changed && fence_bad;
		end
	end
endmodule

[hw/rtl/turtle_pose_engine.sv]
// Top level of the turtle pose engine
//
//  channel   dir  handshake        contents
//  cmd       in   valid / ready    operation, distance, angle_value, target_x, target_y
//  res       out  valid / ready    pose, heading, segment, error_code
//  cfg       in   cfg_we           cfg_index, cfg_wdata (13 bits)
//
// One command at a time: set and home need no iterations, rotate and set angle run a
// ten-step modulo 360, move runs 20 CORDIC iterations and one multiply, and towards
// normalizes its operands (at most 40 shifts) and then runs 20 iterations.
// The result register frees the core: a new command is taken while a result waits.
// Reset is asynchronous and leaves the pose at the default window center, heading 0.
`timescale 1ns / 1ps
`include "turtle_pose_engine_defines.svh"
module turtle_pose_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_wdata,
	tpe_cmd_if.sink     cmd,
	tpe_res_if.source   res
);
	import tpe_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;
	res_t res_w;

	tpe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	tpe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg),
		.operation   (cmd.operation),
		.distance    (cmd.distance),
		.angle_value (cmd.angle_value),
		.target_x    (cmd.target_x),
		.target_y    (cmd.target_y),
		.sts         (sts),
		.res         (res_w)
	);

	assign res.pos_x         = res_w.pos_x;
	assign res.pos_y         = res_w.pos_y;
	assign res.heading       = res_w.heading;
	assign res.segment_valid = res_w.segment_valid;
	assign res.seg_from_x    = res_w.seg_from_x;
	assign res.seg_from_y    = res_w.seg_from_y;
	assign res.seg_to_x      = res_w.seg_to_x;
	assign res.seg_to_y      = res_w.seg_to_y;
	assign res.seg_colour    = res_w.seg_colour;
	assign res.seg_width     = res_w.seg_width;
	assign res.seg_style     = res_w.seg_style;
	assign res.error_code    = res_w.error_code;

	`TPE_ASSERT_NEXT(a_busy_after_take, cmd.valid && cmd.ready, !cmd.ready, "took two commands back to back")
	`TPE_ASSERT_NOW(a_err_no_seg, res.valid && res.error_code, !res.segment_valid, "rejected move drew a segment")
	`TPE_ASSERT_NOW(a_heading_range, res.valid, res.heading < HEADING_MOD, "heading not below 360")
	`TPE_ASSERT_NOW(a_idle_no_iter, cmd.ready, !ctl.cord_step && !ctl.mod_step, "iterating while idle")
endmodule
